[sv/mlsqm_pkg.sv]
`timescale 1ns / 1ps
package mlsqm_pkg;

   localparam int CMD_W  = 2;
   localparam int LIST_W = 3;
   localparam int CPU_W  = 3;
   localparam int SLOT_W = 6;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

   localparam logic [LIST_W-1:0] LIST_RUNNING  = 3'd0;
   localparam logic [LIST_W-1:0] LIST_UNUSED   = 3'd1;
   localparam logic [LIST_W-1:0] LIST_RUNNABLE = 3'd2;
   localparam logic [LIST_W-1:0] LIST_SLEEPING = 3'd3;
   localparam logic [LIST_W-1:0] LIST_ZOMBIE   = 3'd4;

   localparam int HEAD_RUNNING     = 0;
   localparam int HEAD_UNUSED      = 1;
   localparam int HEAD_SLEEPING    = 2;
   localparam int HEAD_ZOMBIE      = 3;
   localparam int NUM_GLOBAL_LISTS = 4;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_HEAD = 5'b00010,
      S_WALK = 5'b00100,
      S_FIX  = 5'b01000,
      S_POP  = 5'b10000
   } state_type;

endpackage

[sv/multi_list_slot_queue_manager.sv]
`timescale 1ns / 1ps
// Slot queue manager: singly linked lists (running, unused, sleeping, zombie and one
// runnable list per CPU) sharing one next-link RAM over SLOTS slots; list heads sit in a
// second RAM. A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_strobe, and the receiver cannot stall it.
// Push and rejected commands answer from the head-read state via the registered strobe.
// Remove and pop walk the list through the one read port of the link RAM, one hop per
// cycle, and a pop on a looped list is cut short once its hop count reaches SLOTS.
// A new command is taken in the cycle its predecessor's result is shown.
module multi_list_slot_queue_manager
   import mlsqm_pkg::*;
#(
   parameter int SLOTS = 64,
   parameter int CPUS  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [LIST_W-1:0] req_list_sel,
   input  logic [CPU_W-1:0]  req_cpu_id,
   input  logic [SLOT_W-1:0] req_slot,
   output logic              rsp_strobe,
   output logic              rsp_ok,
   output logic [SLOT_W-1:0] rsp_popped_slot
);

   localparam int NH  = NUM_GLOBAL_LISTS + CPUS;
   localparam int AW  = $clog2(SLOTS);
   localparam int LW  = $clog2(SLOTS + 1);
   localparam int HW  = $clog2(NH);
   localparam int CW  = (LW > SLOT_W) ? LW : SLOT_W;
   localparam int CTW = 7;
   localparam logic [LW-1:0] END_MARK = LW'(SLOTS);

   function automatic logic [CTW-1:0] cpu_wrap(input logic [CPU_W-1:0] cpu);
      logic [CTW-1:0] v;
      v = CTW'(cpu);
      for (int i = 0; i < (2 ** CPU_W); i++) begin
         if (v >= CTW'(CPUS)) begin
            v = v - CTW'(CPUS);
         end
      end
      return v;
   endfunction

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff;
   logic              go_ff;
   logic [HW-1:0]     hidx_ff;
   logic [LW-1:0]     slot_ff;
   logic [LW-1:0]     cur_ff, cur_in;
   logic [LW-1:0]     pred_ff, pred_in;
   logic              pred_head_ff, pred_head_in;
   logic [LW-1:0]     hops_ff, hops_in;
   logic [NH-1:0]     head_vld_ff, head_vld_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic [SLOT_W-1:0] rsp_popped_slot_ff, rsp_popped_slot_in;

   logic              accept;
   logic              list_ok;
   logic              cmd_ok;
   logic [HW-1:0]     hidx_c;
   logic [CW-1:0]     slot_c;
   logic              slot_in_range;
   logic [LW-1:0]     head_val;
   logic [LW-1:0]     nx;

   logic              link_wr_en, link_rd_en;
   logic [AW-1:0]     link_wr_addr, link_rd_addr;
   logic [LW-1:0]     link_wr_data, link_rd_data;
   logic              head_wr_en, head_rd_en;
   logic [HW-1:0]     head_wr_addr, head_rd_addr;
   logic [LW-1:0]     head_wr_data, head_rd_data;

   mlsqm_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
      .clock   (clock),
      .wr_en   (link_wr_en),
      .wr_addr (link_wr_addr),
      .wr_data (link_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   mlsqm_ram #(.WIDTH(LW), .DEPTH(NH)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      list_ok = 1'b1;
      hidx_c  = '0;
      unique case (req_list_sel)
         LIST_RUNNING:  hidx_c = HW'(HEAD_RUNNING);
         LIST_UNUSED:   hidx_c = HW'(HEAD_UNUSED);
         LIST_RUNNABLE: hidx_c = HW'(NUM_GLOBAL_LISTS + int'(cpu_wrap(req_cpu_id)));
         LIST_SLEEPING: hidx_c = HW'(HEAD_SLEEPING);
         LIST_ZOMBIE:   hidx_c = HW'(HEAD_ZOMBIE);
         default:       list_ok = 1'b0;
      endcase
      slot_c        = CW'(req_slot);
      slot_in_range = (slot_c < CW'(SLOTS));
      unique case (req_cmd) inside
         CMD_PUSH, CMD_REMOVE: cmd_ok = list_ok && slot_in_range;
         CMD_POP:              cmd_ok = list_ok;
         default:              cmd_ok = 1'b0;
      endcase
   end

   assign head_val = head_vld_ff[hidx_ff] ? head_rd_data : END_MARK;

   always_comb begin
      state_in           = state_ff;
      cur_in             = cur_ff;
      pred_in            = pred_ff;
      pred_head_in       = pred_head_ff;
      hops_in            = hops_ff;
      head_vld_in        = head_vld_ff;
      rsp_strobe_in      = 1'b0;
      rsp_ok_in          = 1'b0;
      rsp_popped_slot_in = '0;
      nx                 = '0;
      link_wr_en         = 1'b0;
      link_wr_addr       = '0;
      link_wr_data       = '0;
      link_rd_en         = 1'b0;
      link_rd_addr       = '0;
      head_wr_en         = 1'b0;
      head_wr_addr       = '0;
      head_wr_data       = '0;
      head_rd_en         = 1'b0;
      head_rd_addr       = hidx_c;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               head_rd_en = 1'b1;
               state_in   = S_HEAD;
            end
         end
         S_HEAD: begin
            nx            = head_val;
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            if (go_ff) begin
               case (cmd_ff)
                  CMD_PUSH: begin
                     link_wr_en           = 1'b1;
                     link_wr_addr         = AW'(slot_ff);
                     link_wr_data         = head_val;
                     head_wr_en           = 1'b1;
                     head_wr_addr         = hidx_ff;
                     head_wr_data         = slot_ff;
                     head_vld_in[hidx_ff] = 1'b1;
                     rsp_ok_in            = 1'b1;
                  end
                  CMD_REMOVE: begin
                     if (nx < END_MARK) begin
                        rsp_strobe_in = 1'b0;
                        link_rd_en    = 1'b1;
                        if (nx == slot_ff) begin
                           pred_head_in = 1'b1;
                           link_rd_addr = AW'(slot_ff);
                           state_in     = S_FIX;
                        end else begin
                           cur_in       = nx;
                           hops_in      = LW'(1);
                           link_rd_addr = AW'(nx);
                           state_in     = S_WALK;
                        end
                     end
                  end
                  default: begin
                     if (nx < END_MARK) begin
                        rsp_strobe_in = 1'b0;
                        cur_in        = nx;
                        pred_head_in  = 1'b1;
                        hops_in       = '0;
                        link_rd_en    = 1'b1;
                        link_rd_addr  = AW'(nx);
                        state_in      = S_POP;
                     end
                  end
               endcase
            end
         end
         S_WALK: begin
            nx = link_rd_data;
            if (nx >= END_MARK || hops_ff >= END_MARK) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (nx == slot_ff) begin
               pred_in      = cur_ff;
               pred_head_in = 1'b0;
               link_rd_en   = 1'b1;
               link_rd_addr = AW'(slot_ff);
               state_in     = S_FIX;
            end else begin
               cur_in       = nx;
               hops_in      = hops_ff + LW'(1);
               link_rd_en   = 1'b1;
               link_rd_addr = AW'(nx);
            end
         end
         S_FIX: begin
            if (pred_head_ff) begin
               head_wr_en           = 1'b1;
               head_wr_addr         = hidx_ff;
               head_wr_data         = link_rd_data;
               head_vld_in[hidx_ff] = 1'b1;
            end else begin
               link_wr_en   = 1'b1;
               link_wr_addr = AW'(pred_ff);
               link_wr_data = link_rd_data;
            end
            rsp_strobe_in = 1'b1;
            rsp_ok_in     = 1'b1;
            state_in      = S_IDLE;
         end
         S_POP: begin
            nx = link_rd_data;
            if (hops_ff >= END_MARK) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else if (nx >= END_MARK) begin
               if (pred_head_ff) begin
                  head_vld_in[hidx_ff] = 1'b0;
               end else begin
                  link_wr_en   = 1'b1;
                  link_wr_addr = AW'(pred_ff);
                  link_wr_data = END_MARK;
               end
               rsp_strobe_in      = 1'b1;
               rsp_ok_in          = 1'b1;
               rsp_popped_slot_in = SLOT_W'(cur_ff);
               state_in           = S_IDLE;
            end else begin
               pred_in      = cur_ff;
               pred_head_in = 1'b0;
               cur_in       = nx;
               hops_in      = hops_ff + LW'(1);
               link_rd_en   = 1'b1;
               link_rd_addr = AW'(nx);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_vld_ff   <= '0;
         hops_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_vld_ff   <= head_vld_in;
         hops_ff       <= hops_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_cmd;
         go_ff   <= cmd_ok;
         hidx_ff <= hidx_c;
         slot_ff <= LW'(slot_c);
      end
      cur_ff             <= cur_in;
      pred_ff            <= pred_in;
      pred_head_ff       <= pred_head_in;
      rsp_ok_ff          <= rsp_ok_in;
      rsp_popped_slot_ff <= rsp_popped_slot_in;
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_popped_slot = rsp_popped_slot_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_HEAD)
      else $error("accepted transaction did not start the head read");

   a_strobe_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) != S_IDLE)
      else $error("result strobe without a transaction in flight");

   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> rsp_popped_slot == '0)
      else $error("failed transaction reports a popped slot");

   a_hops_bound: assert property (@(posedge clock) disable iff (reset)
      hops_ff <= END_MARK)
      else $error("walk ran past the slot count");

endmodule

[sv/mlsqm_ram.sv]
`timescale 1ns / 1ps
module mlsqm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
